FILE: hw/rtl/mice_pkg.sv
// Package: mnemonic, kind and mode codes, stage payload types, cycle tables.
package mice_pkg;

  typedef enum logic [4:0] {
    ACT_ADD   = 5'd0,
    ACT_SUB   = 5'd1,
    ACT_ADDA  = 5'd2,
    ACT_SUBA  = 5'd3,
    ACT_AND   = 5'd4,
    ACT_OR    = 5'd5,
    ACT_CMP   = 5'd6,
    ACT_CMPA  = 5'd7,
    ACT_EOR   = 5'd8,
    ACT_DIVS  = 5'd9,
    ACT_DIVU  = 5'd10,
    ACT_MULS  = 5'd11,
    ACT_MULU  = 5'd12,
    ACT_ANDI  = 5'd13,
    ACT_EORI  = 5'd14,
    ACT_ORI   = 5'd15,
    ACT_ADDI  = 5'd16,
    ACT_SUBI  = 5'd17,
    ACT_ADDQ  = 5'd18,
    ACT_SUBQ  = 5'd19,
    ACT_CMPI  = 5'd20,
    ACT_MOVEQ = 5'd21,
    ACT_NEG   = 5'd22,
    ACT_NEGX  = 5'd23,
    ACT_NOT   = 5'd24,
    ACT_CLR   = 5'd25,
    ACT_OTHER = 5'd26
  } action_e;

  typedef enum logic [1:0] {
    KIND_EA    = 2'd0,
    KIND_CCR   = 2'd1,
    KIND_SR    = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    MODE_DN    = 4'd0,
    MODE_AN    = 4'd1,
    MODE_AI    = 4'd2,
    MODE_PI    = 4'd3,
    MODE_PD    = 4'd4,
    MODE_D16AN = 4'd5,
    MODE_D8AN  = 4'd6,
    MODE_ABSW  = 4'd7,
    MODE_ABSL  = 4'd8,
    MODE_D16PC = 4'd9,
    MODE_D8PC  = 4'd10,
    MODE_IMM   = 4'd11,
    MODE_OTHER = 4'd12
  } mode_e;

  localparam int unsigned CountW = 8;
  localparam int unsigned EaW    = 5;
  localparam logic [CountW-1:0] MaxCount = 8'd154;

  // Decode stage result.
  typedef struct packed {
    logic [CountW-1:0] base;
    logic              src_en;
    logic [3:0]        src_mode;
    logic              src_long;
    logic              dst_en;
    logic [3:0]        dst_mode;
    logic              dst_long;
  } dec_t;

  // Lookup stage result.
  typedef struct packed {
    logic [CountW-1:0] base;
    logic [EaW-1:0]    src_cost;
    logic [EaW-1:0]    dst_cost;
  } ea_t;

  // Effective-address cycles; long column is word column plus 4 where nonzero.
  function automatic logic [EaW-1:0] ea_cost(input logic [3:0] mode, input logic lng);
    logic [EaW-1:0] c;
    case (mode) inside
      MODE_AI, MODE_PI, MODE_IMM:          c = 5'd4;
      MODE_PD:                             c = 5'd6;
      MODE_D16AN, MODE_ABSW, MODE_D16PC:   c = 5'd8;
      MODE_D8AN, MODE_D8PC:                c = 5'd10;
      MODE_ABSL:                           c = 5'd12;
      default:                             c = 5'd0;
    endcase
    if (lng && (c != 5'd0)) begin
      c = c + 5'd4;
    end
    return c;
  endfunction

  // CLR table; unknown and PC-relative modes count as Dn.
  function automatic logic [CountW-1:0] clr_cost(input logic [3:0] mode, input logic lng);
    logic [CountW-1:0] c;
    case (mode) inside
      MODE_AN:             c = 8'd0;
      MODE_AI, MODE_PI:    c = lng ? 8'd12 : 8'd8;
      MODE_PD:             c = lng ? 8'd14 : 8'd10;
      MODE_D16AN, MODE_ABSW: c = lng ? 8'd16 : 8'd12;
      MODE_D8AN, MODE_ABSL:  c = lng ? 8'd20 : 8'd16;
      default:             c = lng ? 8'd6 : 8'd4;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/mice_if.sv
// Interfaces: instruction descriptor channel and cycle count channel.
interface mice_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] action;
  logic       op_is_long;
  logic [1:0] src_kind;
  logic [3:0] src_mode;
  logic       src_is_long;
  logic [1:0] dst_kind;
  logic [3:0] dst_mode;
  logic       dst_is_long;

  modport source (
    output valid, action, op_is_long, src_kind, src_mode, src_is_long,
           dst_kind, dst_mode, dst_is_long,
    input  ready
  );
  modport sink (
    input  valid, action, op_is_long, src_kind, src_mode, src_is_long,
           dst_kind, dst_mode, dst_is_long,
    output ready
  );
endinterface

interface mice_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cycle_count;

  modport source (output valid, cycle_count, input ready);
  modport sink (input valid, cycle_count, output ready);
endinterface

FILE: hw/rtl/mice_decode.sv
// Stage 1: mnemonic decode to base cycle count and EA enables.
module mice_decode
  import mice_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  mice_in_if.sink      in_i,
  output logic         valid_o,
  output dec_t         data_o,
  input  logic         ready_i
);

  logic              valid_q;
  dec_t              data_q;
  dec_t              data_d;
  logic [CountW-1:0] base;
  logic              add_ea;
  logic              lng;
  logic              dst_reg;

  assign lng     = in_i.op_is_long;
  assign dst_reg = (in_i.dst_mode == MODE_DN) || (in_i.dst_mode == MODE_AN);

  always_comb begin
    base   = '0;
    add_ea = 1'b0;
    unique case (in_i.action) inside
      ACT_ADD, ACT_SUB, ACT_AND, ACT_OR: begin
        if (in_i.src_kind == KIND_EA) begin
          base = lng ? 8'd6 : 8'd4;
        end else begin
          base = lng ? 8'd12 : 8'd8;
        end
        add_ea = 1'b1;
      end
      ACT_ADDA, ACT_SUBA: begin
        base   = lng ? 8'd6 : 8'd8;
        add_ea = 1'b1;
      end
      ACT_CMP: begin
        base   = lng ? 8'd6 : 8'd4;
        add_ea = 1'b1;
      end
      ACT_CMPA: begin
        base   = 8'd6;
        add_ea = 1'b1;
      end
      ACT_EOR: begin
        if (in_i.dst_mode == MODE_DN) begin
          base = lng ? 8'd6 : 8'd4;
        end else begin
          base = lng ? 8'd12 : 8'd8;
        end
        add_ea = 1'b1;
      end
      ACT_DIVS: begin base = 8'd122; add_ea = 1'b1; end
      ACT_DIVU: begin base = 8'd108; add_ea = 1'b1; end
      ACT_MULS: begin base = 8'd42;  add_ea = 1'b1; end
      ACT_MULU: begin base = 8'd40;  add_ea = 1'b1; end
      ACT_ANDI, ACT_EORI, ACT_ORI, ACT_ADDI, ACT_SUBI: begin
        // status register forms only exist for the logic immediates
        if ((in_i.action != ACT_ADDI) && (in_i.action != ACT_SUBI) &&
            ((in_i.dst_kind == KIND_CCR) || (in_i.dst_kind == KIND_SR))) begin
          base = 8'd16;
        end else if (in_i.dst_mode == MODE_DN) begin
          base = lng ? 8'd14 : 8'd8;
        end else begin
          base   = lng ? 8'd20 : 8'd12;
          add_ea = 1'b1;
        end
      end
      ACT_ADDQ, ACT_SUBQ, ACT_NEG, ACT_NEGX, ACT_NOT: begin
        if (dst_reg) begin
          if ((in_i.action == ACT_ADDQ) || (in_i.action == ACT_SUBQ)) begin
            base = lng ? 8'd8 : 8'd4;
          end else begin
            base = lng ? 8'd6 : 8'd4;
          end
        end else begin
          base   = lng ? 8'd12 : 8'd8;
          add_ea = 1'b1;
        end
      end
      ACT_CMPI: begin
        base   = lng ? 8'd12 : 8'd8;
        add_ea = 1'b1;
      end
      ACT_MOVEQ: base = 8'd4;
      ACT_CLR:   base = clr_cost(in_i.dst_mode, in_i.dst_is_long);
      default:   base = '0;
    endcase
  end

  always_comb begin
    data_d.base     = base;
    data_d.src_en   = add_ea && (in_i.src_kind == KIND_EA);
    data_d.src_mode = in_i.src_mode;
    data_d.src_long = in_i.src_is_long;
    data_d.dst_en   = add_ea && (in_i.dst_kind == KIND_EA);
    data_d.dst_mode = in_i.dst_mode;
    data_d.dst_long = in_i.dst_is_long;
  end

  assign in_i.ready = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/mice_ea_lookup.sv
// Stage 2: effective-address cycle lookup for both operands.
module mice_ea_lookup
  import mice_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  dec_t data_i,
  output logic ready_o,
  output logic valid_o,
  output ea_t  data_o,
  input  logic ready_i
);

  logic valid_q;
  ea_t  data_q;
  ea_t  data_d;

  always_comb begin
    data_d.base     = data_i.base;
    data_d.src_cost = data_i.src_en ? ea_cost(data_i.src_mode, data_i.src_long) : '0;
    data_d.dst_cost = data_i.dst_en ? ea_cost(data_i.dst_mode, data_i.dst_long) : '0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/m68k_instruction_cycle_estimator_unit.sv
// Top level: 68000 worst-case instruction cycle estimator, three-stage pipeline.
// Decode, EA lookup and final add each take one stage, registered in that order.
// Throughput: one beat per cycle while out_o is not stalled.
// Each stage holds its own valid bit and loads whenever it is empty or drains, so
// bubbles are squeezed out while the output stalls.
// Reset (rst_ni low, async) clears all valid bits; payload registers are not reset.
module m68k_instruction_cycle_estimator_unit
  import mice_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  mice_in_if.sink   in_i,
  mice_out_if.source out_o
);

  // stage 1 -> stage 2
  logic dec_valid;
  dec_t dec_data;
  logic dec_ready;

  // stage 2 -> stage 3
  logic ea_valid;
  ea_t  ea_data;
  logic ea_ready;

  // stage 3: output register holding the summed count
  logic              out_valid_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;

  mice_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (dec_valid),
    .data_o  (dec_data),
    .ready_i (dec_ready)
  );

  mice_ea_lookup u_ea_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .data_i  (dec_data),
    .ready_o (dec_ready),
    .valid_o (ea_valid),
    .data_o  (ea_data),
    .ready_i (ea_ready)
  );

  // Worst case 122 + 16 + 16 = 154, so 8 bits never wrap.
  assign count_d = ea_data.base
                 + CountW'(ea_data.src_cost)
                 + CountW'(ea_data.dst_cost);

  assign ea_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ea_ready) begin
      out_valid_q <= ea_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ea_valid && ea_ready) begin
      count_q <= count_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.cycle_count = count_q;

endmodule

FILE: hw/rtl/mice_checker.sv
// Checker: port-level assertions on the estimator, bound to the top level.
module mice_checker
  import mice_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] cycle_count_i
);

  // stalled result beat stays presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(cycle_count_i))
    else $error("result changed while stalled");

  // no count can exceed the slowest divide with two long EA operands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cycle_count_i <= MaxCount)
    else $error("cycle count out of range");

  // an idle pipe, with no result beat and no input offered, must take the next beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !$past(out_valid_i) && !$past(in_valid_i) |-> in_ready_i)
    else $error("input stalled with room in the pipeline");

endmodule

bind m68k_instruction_cycle_estimator_unit mice_checker u_mice_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .cycle_count_i (out_o.cycle_count)
);

FILE: sim/m68k_instruction_cycle_estimator_unit_test.sv
// Self-checking testbench for the 68000 instruction cycle estimator pipeline.
module m68k_instruction_cycle_estimator_unit_test
  import mice_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Codes past the last named ones; the block must treat them as unknown.
  localparam logic [4:0] ACT_UNUSED_TOP  = 5'd31;
  localparam logic [3:0] MODE_UNUSED_TOP = 4'd15;

  localparam int unsigned RANDOM_INSTRS = 1520;
  localparam int unsigned MAX_GAP       = 17;
  // Receiver hold-off long enough to back the pipeline all the way up.
  localparam int unsigned LONG_HOLD     = 300;
  // Pipeline is three stages deep; a few spare edges catch stray beats.
  localparam int unsigned DRAIN_CYCLES  = 10;
  // Worst quiet stretch is the long hold plus reset; give it ample margin.
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PRINT_LIMIT   = 40;

  // One instruction descriptor plus the idle cycles the sender takes after it.
  typedef struct packed {
    logic [4:0] action;
    logic       op_long;
    logic [1:0] src_kind;
    logic [3:0] src_mode;
    logic       src_long;
    logic [1:0] dst_kind;
    logic [3:0] dst_mode;
    logic       dst_long;
    logic [4:0] gap;
  } instr_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mice_in_if  in_bus ();
  mice_out_if out_bus ();

  // TB-side drive registers, known from time zero.
  logic   send_valid  = 1'b0;
  instr_t cur_instr   = '0;
  logic   count_ready = 1'b0;

  assign in_bus.valid       = send_valid;
  assign in_bus.action      = cur_instr.action;
  assign in_bus.op_is_long  = cur_instr.op_long;
  assign in_bus.src_kind    = cur_instr.src_kind;
  assign in_bus.src_mode    = cur_instr.src_mode;
  assign in_bus.src_is_long = cur_instr.src_long;
  assign in_bus.dst_kind    = cur_instr.dst_kind;
  assign in_bus.dst_mode    = cur_instr.dst_mode;
  assign in_bus.dst_is_long = cur_instr.dst_long;
  assign out_bus.ready      = count_ready;

  m68k_instruction_cycle_estimator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  instr_t      pending_instrs[$];
  logic [7:0]  cycle_expect_q[$];
  int unsigned n_accepted = 0;
  int unsigned n_counts   = 0;
  int unsigned n_errors   = 0;
  int unsigned n_holds    = 0;
  logic [31:0] actions_seen = '0;

  task automatic note_error(input string msg);
    if (n_errors < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: timing tables for the 68000, written out per mode.
  // ---------------------------------------------------------------------------

  // Effective-address cycles for one memory operand; Dn, An and unknown modes
  // cost nothing.
  function automatic int unsigned ea_cycles(input logic [3:0] mode, input logic lng);
    int unsigned c;
    case (mode)
      MODE_AI, MODE_PI, MODE_IMM:        c = lng ? 8 : 4;
      MODE_PD:                           c = lng ? 10 : 6;
      MODE_D16AN, MODE_ABSW, MODE_D16PC: c = lng ? 12 : 8;
      MODE_D8AN, MODE_D8PC:              c = lng ? 14 : 10;
      MODE_ABSL:                         c = lng ? 16 : 12;
      default:                           c = 0;
    endcase
    return c;
  endfunction

  // CLR has its own table. An gives 0; PC-relative, immediate and unknown
  // modes fall back to the Dn row.
  function automatic int unsigned clear_cycles(input logic [3:0] mode, input logic lng);
    int unsigned c;
    case (mode)
      MODE_AN:               c = 0;
      MODE_AI, MODE_PI:      c = lng ? 12 : 8;
      MODE_PD:               c = lng ? 14 : 10;
      MODE_D16AN, MODE_ABSW: c = lng ? 16 : 12;
      MODE_D8AN, MODE_ABSL:  c = lng ? 20 : 16;
      default:               c = lng ? 6 : 4;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] predict_cycles(input instr_t d);
    int unsigned total;
    logic        with_ea;
    logic        dst_reg;
    logic        logic_imm;
    total     = 0;
    with_ea   = 1'b0;
    dst_reg   = (d.dst_mode == MODE_DN) || (d.dst_mode == MODE_AN);
    logic_imm = (d.action == ACT_ANDI) || (d.action == ACT_EORI) || (d.action == ACT_ORI);
    case (d.action)
      ACT_ADD, ACT_SUB, ACT_AND, ACT_OR: begin
        // Non-EA source (the SR/CCR style forms) takes the slower row.
        if (d.src_kind == KIND_EA) total = d.op_long ? 6 : 4;
        else                       total = d.op_long ? 12 : 8;
        with_ea = 1'b1;
      end
      ACT_ADDA, ACT_SUBA: begin
        total   = d.op_long ? 6 : 8;
        with_ea = 1'b1;
      end
      ACT_CMP: begin
        total   = d.op_long ? 6 : 4;
        with_ea = 1'b1;
      end
      ACT_CMPA: begin
        total   = 6;
        with_ea = 1'b1;
      end
      ACT_EOR: begin
        if (d.dst_mode == MODE_DN) total = d.op_long ? 6 : 4;
        else                       total = d.op_long ? 12 : 8;
        with_ea = 1'b1;
      end
      ACT_DIVS: begin total = 122; with_ea = 1'b1; end
      ACT_DIVU: begin total = 108; with_ea = 1'b1; end
      ACT_MULS: begin total = 42;  with_ea = 1'b1; end
      ACT_MULU: begin total = 40;  with_ea = 1'b1; end
      ACT_ANDI, ACT_EORI, ACT_ORI, ACT_ADDI, ACT_SUBI: begin
        // Logic immediates aimed at SR/CCR are a flat 16 with no EA cost.
        if (logic_imm && (d.dst_kind == KIND_CCR || d.dst_kind == KIND_SR)) begin
          total = 16;
        end else if (d.dst_mode == MODE_DN) begin
          total = d.op_long ? 14 : 8;
        end else begin
          total   = d.op_long ? 20 : 12;
          with_ea = 1'b1;
        end
      end
      ACT_ADDQ, ACT_SUBQ: begin
        if (dst_reg) begin
          total = d.op_long ? 8 : 4;
        end else begin
          total   = d.op_long ? 12 : 8;
          with_ea = 1'b1;
        end
      end
      ACT_CMPI: begin
        total   = d.op_long ? 12 : 8;
        with_ea = 1'b1;
      end
      ACT_MOVEQ: total = 4;
      ACT_NEG, ACT_NEGX, ACT_NOT: begin
        if (dst_reg) begin
          total = d.op_long ? 6 : 4;
        end else begin
          total   = d.op_long ? 12 : 8;
          with_ea = 1'b1;
        end
      end
      ACT_CLR: total = clear_cycles(d.dst_mode, d.dst_long);
      default: total = 0;
    endcase
    // Only operands of kind EA pick up addressing cycles.
    if (with_ea) begin
      if (d.src_kind == KIND_EA) total += ea_cycles(d.src_mode, d.src_long);
      if (d.dst_kind == KIND_EA) total += ea_cycles(d.dst_mode, d.dst_long);
    end
    return 8'(total);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus shaping.
  // ---------------------------------------------------------------------------

  // Sender idle per instruction. Runs of back-to-back beats alternate with
  // random gaps; the window around the first long receiver hold-off is kept
  // gap-free so the pipeline fills and in_bus.ready drops.
  function automatic logic [4:0] draw_gap(input int unsigned idx);
    logic [4:0] g;
    if (idx >= 380 && idx < 720) begin
      g = '0;
    end else begin
      case ((idx / 120) % 3)
        0:       g = '0;
        1:       g = 5'($urandom_range(0, MAX_GAP));
        default: g = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, MAX_GAP)) : 5'd0;
      endcase
    end
    return g;
  endfunction

  // Receiver stall after each count beat, phased the same way.
  function automatic int unsigned draw_stall(input int unsigned idx);
    int unsigned s;
    case ((idx / 150) % 3)
      0:       s = 0;
      1:       s = $urandom_range(0, MAX_GAP);
      default: s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
    endcase
    return s;
  endfunction

  task automatic queue_instr(input instr_t d);
    d.gap = draw_gap(pending_instrs.size());
    pending_instrs.push_back(d);
  endtask

  task automatic add_directed(input logic [4:0] act, input logic ol,
                              input logic [1:0] sk, input logic [3:0] sm, input logic sl,
                              input logic [1:0] dk, input logic [3:0] dm, input logic dl);
    instr_t d;
    d = '{act, ol, sk, sm, sl, dk, dm, dl, 5'd0};
    queue_instr(d);
  endtask

  // Random descriptor: mostly known mnemonics and modes, kinds biased to EA,
  // with enough unknown codes that every field bit toggles.
  function automatic instr_t random_instr();
    instr_t d;
    if ($urandom_range(0, 9) == 0) d.action = 5'($urandom_range(ACT_OTHER, ACT_UNUSED_TOP));
    else                           d.action = 5'($urandom_range(ACT_ADD, ACT_CLR));
    d.op_long  = 1'($urandom_range(0, 1));
    d.src_kind = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(KIND_CCR, KIND_OTHER)) : KIND_EA;
    d.dst_kind = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(KIND_CCR, KIND_OTHER)) : KIND_EA;
    d.src_mode = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(MODE_OTHER, MODE_UNUSED_TOP))
                                             : 4'($urandom_range(MODE_DN, MODE_IMM));
    d.dst_mode = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(MODE_OTHER, MODE_UNUSED_TOP))
                                             : 4'($urandom_range(MODE_DN, MODE_IMM));
    d.src_long = 1'($urandom_range(0, 1));
    d.dst_long = 1'($urandom_range(0, 1));
    d.gap      = '0;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the pending instructions, holds each beat until taken,
  // then idles for that instruction's gap. Accepted beats go to the predictor.
  // ---------------------------------------------------------------------------
  int unsigned send_gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    instr_t nxt;
    if (!rst_ni) begin
      send_valid    <= 1'b0;
      cur_instr     <= '0;
      send_gap_left = 0;
    end else begin
      if (send_valid && in_bus.ready) begin
        cycle_expect_q.push_back(predict_cycles(cur_instr));
        actions_seen[cur_instr.action] = 1'b1;
        n_accepted++;
      end
      // Free to move on when nothing is offered or the offer was just taken.
      if (!send_valid || in_bus.ready) begin
        if (send_gap_left > 0) begin
          send_gap_left--;
          send_valid <= 1'b0;
        end else if (pending_instrs.size() != 0) begin
          nxt           = pending_instrs.pop_front();
          cur_instr     <= nxt;
          send_valid    <= 1'b1;
          send_gap_left = nxt.gap;
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each count beat against the oldest prediction and stalls
  // the output between beats. Twice in the run it holds ready low for a long
  // stretch so the pipeline backs up into the input.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      count_ready <= 1'b0;
      hold_left   = 0;
    end else begin
      if (out_bus.valid && count_ready) begin
        if (cycle_expect_q.size() == 0) begin
          note_error($sformatf("cycle_count %0d with no instruction outstanding",
                               out_bus.cycle_count));
        end else begin
          want = cycle_expect_q.pop_front();
          if (out_bus.cycle_count !== want) begin
            note_error($sformatf("beat %0d: cycle_count %0d, expected %0d",
                                 n_counts, out_bus.cycle_count, want));
          end
        end
        n_counts++;
        if (n_counts % 700 == 400) begin
          hold_left = LONG_HOLD;
          n_holds++;
        end else begin
          hold_left = draw_stall(n_counts);
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end
      count_ready <= (hold_left == 0);
    end
  end

  // Watchdog: ends the run if neither side moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((send_valid && in_bus.ready) || (out_bus.valid && count_ready)) quiet = 0;
      else                                                              quiet++;
    end
    $display("watchdog: no beat for %0d cycles, %0d of %0d counts outstanding",
             QUIET_LIMIT, cycle_expect_q.size(), n_accepted);
    $display("** m68k_instruction_cycle_estimator_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the stimulus, release reset, wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned n_planned;
    int unsigned n_codes;

    // Directed: every mnemonic, all-zero and all-one descriptors, heaviest
    // divide, SR/CCR forms of the logic immediates, register forms of
    // NEG and NOT, CLR off its table, unknown modes and mnemonics.
    add_directed(ACT_ADD,  1'b0, KIND_EA,    MODE_DN,    1'b0, KIND_EA,    MODE_DN,    1'b0);
    add_directed(ACT_ADD,  1'b1, KIND_EA,    MODE_D8PC,  1'b1, KIND_EA,    MODE_ABSL,  1'b1);
    add_directed(ACT_SUB,  1'b0, KIND_CCR,   MODE_ABSL,  1'b1, KIND_EA,    MODE_UNUSED_TOP, 1'b1);
    add_directed(ACT_ADDA, 1'b0, KIND_EA,    MODE_IMM,   1'b0, KIND_EA,    MODE_AN,    1'b1);
    add_directed(ACT_SUBA, 1'b1, KIND_EA,    MODE_OTHER, 1'b1, KIND_OTHER, MODE_PD,    1'b0);
    add_directed(ACT_AND,  1'b1, KIND_SR,    MODE_AI,    1'b0, KIND_EA,    MODE_ABSW,  1'b0);
    add_directed(ACT_OR,   1'b0, KIND_OTHER, MODE_PI,    1'b1, KIND_EA,    MODE_D16AN, 1'b1);
    add_directed(ACT_CMP,  1'b1, KIND_EA,    MODE_ABSL,  1'b1, KIND_EA,    MODE_DN,    1'b1);
    add_directed(ACT_CMPA, 1'b0, KIND_EA,    MODE_D8AN,  1'b0, KIND_EA,    MODE_AN,    1'b1);
    add_directed(ACT_EOR,  1'b1, KIND_EA,    MODE_DN,    1'b1, KIND_EA,    MODE_DN,    1'b1);
    add_directed(ACT_EOR,  1'b0, KIND_EA,    MODE_DN,    1'b0, KIND_EA,    MODE_D16PC, 1'b0);
    add_directed(ACT_DIVS, 1'b0, KIND_EA,    MODE_ABSL,  1'b1, KIND_EA,    MODE_ABSL,  1'b1);
    add_directed(ACT_DIVU, 1'b0, KIND_EA,    MODE_D16PC, 1'b0, KIND_SR,    MODE_ABSL,  1'b1);
    add_directed(ACT_MULS, 1'b1, KIND_CCR,   MODE_PD,    1'b1, KIND_EA,    MODE_PI,    1'b0);
    add_directed(ACT_MULU, 1'b0, KIND_EA,    MODE_OTHER, 1'b1, KIND_EA,    MODE_AI,    1'b1);
    add_directed(ACT_ANDI, 1'b0, KIND_EA,    MODE_IMM,   1'b0, KIND_SR,    MODE_ABSL,  1'b1);
    add_directed(ACT_EORI, 1'b1, KIND_EA,    MODE_IMM,   1'b1, KIND_CCR,   MODE_D8AN,  1'b0);
    add_directed(ACT_ORI,  1'b1, KIND_EA,    MODE_IMM,   1'b1, KIND_EA,    MODE_DN,    1'b1);
    add_directed(ACT_ADDI, 1'b0, KIND_EA,    MODE_IMM,   1'b0, KIND_SR,    MODE_ABSW,  1'b0);
    add_directed(ACT_SUBI, 1'b1, KIND_EA,    MODE_IMM,   1'b1, KIND_EA,    MODE_D8PC,  1'b1);
    add_directed(ACT_ADDQ, 1'b1, KIND_OTHER, MODE_IMM,   1'b0, KIND_EA,    MODE_AN,    1'b1);
    add_directed(ACT_SUBQ, 1'b0, KIND_EA,    MODE_IMM,   1'b0, KIND_EA,    MODE_PD,    1'b0);
    add_directed(ACT_CMPI, 1'b1, KIND_EA,    MODE_IMM,   1'b1, KIND_EA,    MODE_D16AN, 1'b1);
    add_directed(ACT_MOVEQ, 1'b1, KIND_EA,   MODE_ABSL,  1'b1, KIND_EA,    MODE_ABSL,  1'b1);
    add_directed(ACT_NEG,  1'b0, KIND_EA,    MODE_AI,    1'b0, KIND_EA,    MODE_AN,    1'b0);
    add_directed(ACT_NEGX, 1'b1, KIND_EA,    MODE_DN,    1'b0, KIND_EA,    MODE_ABSL,  1'b1);
    add_directed(ACT_NOT,  1'b0, KIND_OTHER, MODE_DN,    1'b0, KIND_EA,    MODE_DN,    1'b0);
    add_directed(ACT_CLR,  1'b0, KIND_EA,    MODE_DN,    1'b0, KIND_EA,    MODE_AN,    1'b0);
    add_directed(ACT_CLR,  1'b1, KIND_EA,    MODE_ABSL,  1'b1, KIND_EA,    MODE_D16PC, 1'b1);
    add_directed(ACT_CLR,  1'b1, KIND_EA,    MODE_DN,    1'b0, KIND_EA,    MODE_UNUSED_TOP, 1'b0);
    add_directed(ACT_OTHER, 1'b1, KIND_EA,   MODE_ABSL,  1'b1, KIND_EA,    MODE_ABSL,  1'b1);
    add_directed(ACT_UNUSED_TOP, 1'b1, KIND_OTHER, MODE_UNUSED_TOP, 1'b1,
                 KIND_OTHER, MODE_UNUSED_TOP, 1'b1);

    repeat (RANDOM_INSTRS) queue_instr(random_instr());
    n_planned = pending_instrs.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_planned) @(posedge clk_i);
    while (cycle_expect_q.size() != 0) @(posedge clk_i);
    // A few more edges so any extra count beat is caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    n_codes = $countones(actions_seen);
    $display("Sent %0d instruction descriptors covering %0d mnemonic codes; checked %0d counts.",
             n_accepted, n_codes, n_counts);
    $display("Output held off %0d times for %0d cycles; %0d mismatches.",
             n_holds, LONG_HOLD, n_errors);
    if (n_errors == 0) begin
      $display("** m68k_instruction_cycle_estimator_unit: PASSED **");
    end else begin
      $display("** m68k_instruction_cycle_estimator_unit: FAILED **");
    end
    $finish;
  end

endmodule
